FILE: rtl/gbr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbr_pkg
// Shared constants, register indexes and helpers for the glyph renderer.
// ----------------------------------------------------------------------------
package gbr_pkg;

    // Font geometry
    localparam int GLYPH_COUNT = 256;
    localparam int GLYPH_ROWS  = 8;
    localparam int GLYPH_COLS  = 8;
    localparam int ROW_BITS_W  = 8;
    localparam int GLYPH_W     = $clog2(GLYPH_COUNT);
    localparam int ROW_W       = $clog2(GLYPH_ROWS);
    localparam int COL_W       = $clog2(GLYPH_COLS);
    localparam int STORE_DEPTH = GLYPH_COUNT * GLYPH_ROWS;
    localparam int STORE_AW    = GLYPH_W + ROW_W;

    // Field widths
    localparam int CODE_W  = 8;
    localparam int POS_W   = 12;
    localparam int LW_W    = 13;
    localparam int WORD_W  = 32;
    localparam int PROD_W  = POS_W + LW_W;
    localparam int IN_W    = 48;
    localparam int OUT_W   = 64;
    localparam int CFG_AW  = 3;

    // Command codes carried on tuser
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_DRAW = 1'b1;

    // Register indexes
    localparam logic [CFG_AW-1:0] CFG_FG_COLOR    = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_BG_COLOR    = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_TRANSPARENT = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_LINE_WIDTH  = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_FB_BASE     = 3'd4;

    // Register reset values
    localparam logic [WORD_W-1:0] FG_RESET = 32'h00FF_FFFF;
    localparam logic [LW_W-1:0]   LW_RESET = 13'd640;

    // Reduce a glyph code into the store, one conditional subtract per bit
    function automatic logic [GLYPH_W-1:0] f_glyph_index(input logic [CODE_W-1:0] code);
        logic [15:0] v;
        v = {8'd0, code};
        for (int k = CODE_W - 1; k >= 0; k--) begin
            if (v >= (16'(GLYPH_COUNT) << k)) begin
                v = v - (16'(GLYPH_COUNT) << k);
            end
        end
        return v[GLYPH_W-1:0];
    endfunction

endpackage

FILE: rtl/gbr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module gbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, hold data between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/glyph_bitmap_renderer_top.sv
`timescale 1ns / 1ps
// Load item: taken in idle without leaving it, writes one row into the font RAM, no result.
// Draw item: setup states for the line multiply and the base add, a column walk over
// the 64 pixels of the glyph and a flush state; no command is taken until the draw is back in idle.
// The column walk, one pixel decision per cycle while the output is not blocked, sets the rate.
// The first pixel waits in the pending register until a newer pixel or the flush pushes it out.
// Reset (synchronous, active low) clears control state and config, not the font RAM.
// ----------------------------------------------------------------------------
// glyph_bitmap_renderer_top
// Renders 8x8 font glyphs as a stream of frame buffer pixel writes.
// ----------------------------------------------------------------------------
module glyph_bitmap_renderer_top
    import gbr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Configuration write port
    input  logic               i_cfg_we,
    input  logic [CFG_AW-1:0]  i_cfg_addr,
    input  logic [WORD_W-1:0]  i_cfg_data,
    // Command stream
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // tdata: glyph_code[7:0], row_index[10:8], row_bits[18:11],
    //        x_pos[30:19], y_pos[42:31], zero pad[47:43]
    input  logic [IN_W-1:0]    s_axis_tdata,
    // tuser: cmd (0 load row, 1 draw glyph)
    input  logic               s_axis_tuser,
    // Pixel stream
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // tdata: pixel_address[31:0], pixel_color[63:32]
    output logic [OUT_W-1:0]   m_axis_tdata,
    // tlast: last_pixel
    output logic               m_axis_tlast
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_BASE = 3'd2;
    localparam logic [2:0] S_COL  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    localparam logic [COL_W-1:0] COL_LAST = COL_W'(GLYPH_COLS - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(GLYPH_ROWS - 1);

    // Configuration registers
    logic [WORD_W-1:0] r_fg_color;
    logic [WORD_W-1:0] r_bg_color;
    logic              r_transparent;
    logic [LW_W-1:0]   r_line_width;
    logic [WORD_W-1:0] r_fb_base;

    // Sequencer
    logic [2:0]          r_state;
    logic [GLYPH_W-1:0]  r_glyph;
    logic [POS_W-1:0]    r_x;
    logic [POS_W-1:0]    r_y;
    logic [PROD_W-1:0]   r_prod;
    logic [WORD_W-1:0]   r_row_addr;
    logic [ROW_W-1:0]    r_row;
    logic [COL_W-1:0]    r_col;
    logic [ROW_BITS_W-1:0] r_pattern;

    // Pending pixel and output register
    logic              r_pend_vld;
    logic [WORD_W-1:0] r_pend_addr;
    logic [WORD_W-1:0] r_pend_color;
    logic              r_out_vld;
    logic [WORD_W-1:0] r_out_addr;
    logic [WORD_W-1:0] r_out_color;
    logic              r_out_last;

    // Input field views
    logic [CODE_W-1:0]     w_code;
    logic [ROW_W-1:0]      w_row_index;
    logic [ROW_BITS_W-1:0] w_row_bits;
    logic [POS_W-1:0]      w_x_pos;
    logic [POS_W-1:0]      w_y_pos;

    logic                  w_in_xfer;
    logic                  w_load;
    logic                  w_draw;
    logic                  w_re;
    logic [STORE_AW-1:0]   w_raddr;
    logic [ROW_BITS_W-1:0] w_rdata;
    logic [ROW_BITS_W-1:0] w_bits;
    logic                  w_set;
    logic                  w_emit;
    logic                  w_out_free;
    logic                  w_col_stall;
    logic                  w_advance;
    logic                  w_push;
    logic                  w_push_last;
    logic [WORD_W-1:0]     w_pix_addr;
    logic [WORD_W-1:0]     w_pix_color;

    assign w_code      = s_axis_tdata[7:0];
    assign w_row_index = s_axis_tdata[10:8];
    assign w_row_bits  = s_axis_tdata[18:11];
    assign w_x_pos     = s_axis_tdata[30:19];
    assign w_y_pos     = s_axis_tdata[42:31];

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;
    assign w_load        = w_in_xfer && (s_axis_tuser == CMD_LOAD);
    assign w_draw        = w_in_xfer && (s_axis_tuser == CMD_DRAW);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg_color    <= FG_RESET;
            r_bg_color    <= '0;
            r_transparent <= 1'b0;
            r_line_width  <= LW_RESET;
            r_fb_base     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_FG_COLOR:    r_fg_color    <= i_cfg_data;
                CFG_BG_COLOR:    r_bg_color    <= i_cfg_data;
                CFG_TRANSPARENT: r_transparent <= i_cfg_data[0];
                CFG_LINE_WIDTH:  r_line_width  <= i_cfg_data[LW_W-1:0];
                CFG_FB_BASE:     r_fb_base     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Font row reads: row 0 in the base cycle, the next row on the last column
    always_comb begin
        w_re    = 1'b0;
        w_raddr = {r_glyph, r_row + ROW_W'(1)};
        if (r_state == S_BASE) begin
            w_re    = 1'b1;
            w_raddr = {r_glyph, {ROW_W{1'b0}}};
        end else if (r_state == S_COL && w_advance && r_col == COL_LAST && r_row != ROW_LAST) begin
            w_re = 1'b1;
        end
    end

    gbr_ram #(
        .WIDTH(ROW_BITS_W),
        .DEPTH(STORE_DEPTH)
    ) u_font_ram (
        .i_clk   (i_clk),
        .i_we    (w_load),
        .i_waddr ({f_glyph_index(w_code), w_row_index}),
        .i_wdata (w_row_bits),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Pixel decision for the current column
    assign w_bits      = (r_col == '0) ? w_rdata : r_pattern;
    assign w_set       = w_bits[ROW_BITS_W-1];
    assign w_emit      = w_set || !r_transparent;
    assign w_out_free  = !r_out_vld || m_axis_tready;
    assign w_col_stall = w_emit && r_pend_vld && !w_out_free;
    assign w_advance   = (r_state == S_COL) && !w_col_stall;
    assign w_pix_addr  = r_row_addr + WORD_W'(r_col);
    assign w_pix_color = w_set ? r_fg_color : r_bg_color;

    // Push the pending pixel out when a newer one replaces it, or at the end
    assign w_push_last = (r_state == S_DONE) && r_pend_vld && w_out_free;
    assign w_push      = (w_advance && w_emit && r_pend_vld) || w_push_last;

    // Sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_draw) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL:  r_state <= S_BASE;
                S_BASE: r_state <= S_COL;
                S_COL: begin
                    if (w_advance && r_col == COL_LAST && r_row == ROW_LAST) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_pend_vld || w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Draw datapath: line offset, row base, column walk
    always_ff @(posedge i_clk) begin
        if (w_draw) begin
            r_glyph <= f_glyph_index(w_code);
            r_x     <= w_x_pos;
            r_y     <= w_y_pos;
        end
        if (r_state == S_MUL) begin
            r_prod <= PROD_W'(r_y) * PROD_W'(r_line_width);
        end
        if (r_state == S_BASE) begin
            r_row_addr <= r_fb_base + WORD_W'(r_x) + WORD_W'(r_prod);
            r_row      <= '0;
            r_col      <= '0;
        end
        if (w_advance) begin
            r_pattern <= {w_bits[ROW_BITS_W-2:0], 1'b0};
            r_col     <= r_col + COL_W'(1);
            if (r_col == COL_LAST) begin
                r_row      <= r_row + ROW_W'(1);
                r_row_addr <= r_row_addr + WORD_W'(r_line_width);
            end
        end
    end

    // Pending pixel valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_vld <= 1'b0;
        end else if (w_advance && w_emit) begin
            r_pend_vld <= 1'b1;
        end else if (w_push_last) begin
            r_pend_vld <= 1'b0;
        end
    end

    // Pending pixel payload
    always_ff @(posedge i_clk) begin
        if (w_advance && w_emit) begin
            r_pend_addr  <= w_pix_addr;
            r_pend_color <= w_pix_color;
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_push) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_out_addr  <= r_pend_addr;
            r_out_color <= r_pend_color;
            r_out_last  <= w_push_last;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {r_out_color, r_out_addr};
    assign m_axis_tlast  = r_out_last;

    // A new command is taken only once the pending pixel is flushed
    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !r_pend_vld)
        else $error("command taken with a pixel still pending");

    // A blocked column holds its position
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COL && w_col_stall) |=> (r_state == S_COL && $stable(r_col)
            && $stable(r_row)))
        else $error("column walk moved while output was blocked");

    // Nothing left to flush returns to idle at once
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !r_pend_vld) |=> (r_state == S_IDLE))
        else $error("draw did not finish after the flush");

endmodule

FILE: verif/glyph_bitmap_renderer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_bitmap_renderer_checker
// Watches the config port and both streams of the glyph renderer. It keeps a
// shadow font store and register set, works out the pixel writes of every
// accepted draw, and compares each pixel transfer with the oldest one
// outstanding.
// ----------------------------------------------------------------------------
module glyph_bitmap_renderer_checker
    import gbr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CFG_AW-1:0]  i_cfg_addr,
    input  logic [WORD_W-1:0]  i_cfg_data,
    input  logic               i_s_tvalid,
    input  logic               i_s_tready,
    // tdata: glyph_code[7:0], row_index[10:8], row_bits[18:11],
    //        x_pos[30:19], y_pos[42:31], zero pad[47:43]
    input  logic [IN_W-1:0]    i_s_tdata,
    // tuser: cmd
    input  logic               i_s_tuser,
    input  logic               i_m_tvalid,
    input  logic               i_m_tready,
    // tdata: pixel_address[31:0], pixel_color[63:32]
    input  logic [OUT_W-1:0]   i_m_tdata,
    input  logic               i_m_tlast,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef struct packed {
        logic [WORD_W-1:0] addr;
        logic [WORD_W-1:0] color;
        logic              last;
    } t_pixel_write;

    logic [ROW_BITS_W-1:0] font_rows [STORE_DEPTH];
    logic [WORD_W-1:0]     fg_color;
    logic [WORD_W-1:0]     bg_color;
    logic                  transparent;
    logic [LW_W-1:0]       line_width;
    logic [WORD_W-1:0]     fb_base;
    t_pixel_write          expected_pixels [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic int glyph_slot(input logic [CODE_W-1:0] code, input int row);
        return (int'(code) % GLYPH_COUNT) * GLYPH_ROWS + row;
    endfunction

    // Walk rows then columns, MSB first; mark the final write of the glyph
    task automatic render_glyph(input logic [CODE_W-1:0] code,
                                input logic [POS_W-1:0] x, input logic [POS_W-1:0] y);
        logic [ROW_BITS_W-1:0] pattern;
        logic [WORD_W-1:0]     line;
        logic [WORD_W-1:0]     r32;
        logic [WORD_W-1:0]     c32;
        logic                  bit_set;
        t_pixel_write          held;
        bit                    have_held;
        have_held = 1'b0;
        held      = '0;
        for (int row = 0; row < GLYPH_ROWS; row++) begin
            r32     = row;
            pattern = font_rows[glyph_slot(code, row)];
            line    = (WORD_W'(y) + r32) * WORD_W'(line_width);
            for (int col = 0; col < GLYPH_COLS; col++) begin
                c32     = col;
                bit_set = pattern[ROW_BITS_W-1-col];
                if (!bit_set && transparent) begin
                    continue;
                end
                if (have_held) begin
                    expected_pixels.push_back(held);
                end
                held.addr  = fb_base + WORD_W'(x) + c32 + line;
                held.color = bit_set ? fg_color : bg_color;
                held.last  = 1'b0;
                have_held  = 1'b1;
            end
        end
        if (have_held) begin
            held.last = 1'b1;
            expected_pixels.push_back(held);
        end
    endtask

    // Track config, predict on command transfers, compare pixel transfers
    always @(posedge i_clk) begin
        t_pixel_write want;
        if (!i_rst_n) begin
            fg_color    = FG_RESET;
            bg_color    = '0;
            transparent = 1'b0;
            line_width  = LW_RESET;
            fb_base     = '0;
            expected_pixels.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_FG_COLOR:    fg_color    = i_cfg_data;
                    CFG_BG_COLOR:    bg_color    = i_cfg_data;
                    CFG_TRANSPARENT: transparent = i_cfg_data[0];
                    CFG_LINE_WIDTH:  line_width  = i_cfg_data[LW_W-1:0];
                    CFG_FB_BASE:     fb_base     = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser == CMD_LOAD) begin
                    font_rows[glyph_slot(i_s_tdata[7:0], int'(i_s_tdata[10:8]))] =
                        i_s_tdata[18:11];
                end else begin
                    render_glyph(i_s_tdata[7:0], i_s_tdata[30:19], i_s_tdata[42:31]);
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                if (expected_pixels.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: pixel transfer expected none actual addr %h color %h last %b",
                             $realtime, i_m_tdata[31:0], i_m_tdata[63:32], i_m_tlast);
                end else begin
                    want = expected_pixels.pop_front();
                    if (i_m_tdata[31:0] !== want.addr) begin
                        o_fail_count++;
                        $display("%0t: pixel_address expected %h actual %h",
                                 $realtime, want.addr, i_m_tdata[31:0]);
                    end
                    if (i_m_tdata[63:32] !== want.color) begin
                        o_fail_count++;
                        $display("%0t: pixel_color expected %h actual %h",
                                 $realtime, want.color, i_m_tdata[63:32]);
                    end
                    if (i_m_tlast !== want.last) begin
                        o_fail_count++;
                        $display("%0t: last_pixel expected %b actual %b",
                                 $realtime, want.last, i_m_tlast);
                    end
                end
            end
        end
        o_pending = expected_pixels.size();
    end

endmodule

FILE: verif/glyph_bitmap_renderer_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_bitmap_renderer_top_tb
// Drives font row loads and glyph draws into the renderer under several
// register settings and idle patterns; the checker beside the block predicts
// and compares every pixel write.
// ----------------------------------------------------------------------------
module glyph_bitmap_renderer_top_tb;
    import gbr_pkg::*;

    localparam int QUIET_LIMIT  = 5000;
    localparam int SETTLE_CYCLES = 80;
    localparam int PHASE_ITEMS  = 76;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [CFG_AW-1:0]  i_cfg_addr;
    logic [WORD_W-1:0]  i_cfg_data;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [IN_W-1:0]    s_axis_tdata;
    logic               s_axis_tuser;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [OUT_W-1:0]   m_axis_tdata;
    logic               m_axis_tlast;

    int                 mismatch_count;
    int                 pending_pixels;
    int                 src_idle_pct;
    int                 snk_idle_pct;
    int                 quiet_cycles;
    logic [7:0]         rows_loaded [GLYPH_COUNT];
    int                 full_glyphs [$];

    glyph_bitmap_renderer_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    glyph_bitmap_renderer_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tlast    (m_axis_tlast),
        .o_fail_count (mismatch_count),
        .o_pending    (pending_pixels)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Receiver: drop ready at random on every falling edge
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    // Watchdog: end the run after too many cycles with no transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [IN_W-1:0] pack_cmd(input logic [7:0] code, input logic [2:0] row,
                                                 input logic [7:0] bits, input logic [11:0] x,
                                                 input logic [11:0] y);
        return {5'd0, y, x, bits, row, code};
    endfunction

    function automatic logic [7:0] pick_row_bits();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [11:0] pick_pos();
        case ($urandom_range(0, 7))
            0: return 12'h000;
            1: return 12'hFFF;
            default: return 12'($urandom);
        endcase
    endfunction

    // Present one command, idling first at random, and hold it until the transfer
    task automatic push_cmd(input logic cmd, input logic [IN_W-1:0] data);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= data;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic load_row(input logic [7:0] code, input logic [2:0] row,
                            input logic [7:0] bits);
        push_cmd(CMD_LOAD, pack_cmd(code, row, bits, 12'($urandom), 12'($urandom)));
        if (rows_loaded[code] != 8'hFF) begin
            rows_loaded[code][row] = 1'b1;
            if (rows_loaded[code] == 8'hFF) begin
                full_glyphs.push_back(int'(code));
            end
        end
    endtask

    task automatic load_glyph(input logic [7:0] code);
        for (int r = 0; r < GLYPH_ROWS; r++) begin
            load_row(code, 3'(r), pick_row_bits());
        end
    endtask

    // Row index and row bits are don't-care on a draw: fill them with noise
    task automatic draw_glyph(input logic [7:0] code, input logic [11:0] x,
                              input logic [11:0] y);
        push_cmd(CMD_DRAW, pack_cmd(code, 3'($urandom), 8'($urandom), x, y));
    endtask

    task automatic cfg_write(input logic [CFG_AW-1:0] addr, input logic [WORD_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Drain all pixels, then give a blank transparent draw time to finish
    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_pixels != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Mostly well-formed traffic: whole-glyph loads, row reloads and draws
    task automatic run_random(input int n_items);
        int count;
        int roll;
        count = 0;
        while (count < n_items) begin
            roll = $urandom_range(0, 99);
            if (full_glyphs.size() == 0 || roll < 15) begin
                load_glyph(8'($urandom));
                count += GLYPH_ROWS;
            end else if (roll < 45) begin
                load_row(8'(full_glyphs[$urandom_range(0, full_glyphs.size() - 1)]),
                         3'($urandom), pick_row_bits());
                count++;
            end else begin
                draw_glyph(8'(full_glyphs[$urandom_range(0, full_glyphs.size() - 1)]),
                           pick_pos(), pick_pos());
                count++;
            end
        end
    endtask

    initial begin
        for (int g = 0; g < GLYPH_COUNT; g++) begin
            rows_loaded[g] = 8'h00;
        end
        src_idle_pct  = 19;
        snk_idle_pct  = 82;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_LOAD;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: glyph 0 with edge patterns, glyph 255 left blank
        load_row(8'd0, 3'd0, 8'h80);
        load_row(8'd0, 3'd1, 8'h01);
        load_row(8'd0, 3'd2, 8'hFF);
        load_row(8'd0, 3'd3, 8'h00);
        load_row(8'd0, 3'd4, 8'hAA);
        load_row(8'd0, 3'd5, 8'h55);
        load_row(8'd0, 3'd6, 8'h81);
        load_row(8'd0, 3'd7, 8'h7E);
        for (int r = 0; r < GLYPH_ROWS; r++) begin
            load_row(8'd255, 3'(r), 8'h00);
        end
        // Reset register values, opaque blank glyph
        draw_glyph(8'd0, 12'h000, 12'h000);
        draw_glyph(8'd255, 12'hFFF, 12'hFFF);
        settle();

        // Transparent, widest legal stride, base wrapping past 2^32
        cfg_write(CFG_FG_COLOR, 32'hFFFF_FFFF);
        cfg_write(CFG_BG_COLOR, $urandom);
        cfg_write(CFG_TRANSPARENT, 32'd1);
        cfg_write(CFG_LINE_WIDTH, 32'd4096);
        cfg_write(CFG_FB_BASE, 32'hFFFF_FFFF);
        draw_glyph(8'd0, 12'hFFF, 12'h000);
        draw_glyph(8'd255, 12'h000, 12'hFFF);
        settle();

        // Stride out of range: zero, then the largest the register holds
        cfg_write(CFG_LINE_WIDTH, 32'd0);
        draw_glyph(8'd0, 12'h123, 12'hFFF);
        settle();
        cfg_write(CFG_TRANSPARENT, 32'd0);
        cfg_write(CFG_LINE_WIDTH, 32'h1FFF);
        draw_glyph(8'd0, 12'hFFF, 12'hFFF);
        settle();

        // Random, sender idles lightly and receiver heavily
        cfg_write(CFG_FG_COLOR, $urandom);
        cfg_write(CFG_BG_COLOR, $urandom);
        cfg_write(CFG_LINE_WIDTH, $urandom_range(1, 4096));
        cfg_write(CFG_FB_BASE, $urandom);
        run_random(PHASE_ITEMS);
        settle();

        // Random, idling reversed, transparent with unit stride
        src_idle_pct = 82;
        snk_idle_pct = 19;
        cfg_write(CFG_FG_COLOR, 32'h0000_0000);
        cfg_write(CFG_BG_COLOR, 32'hFFFF_FFFF);
        cfg_write(CFG_TRANSPARENT, 32'd1);
        cfg_write(CFG_LINE_WIDTH, 32'd1);
        cfg_write(CFG_FB_BASE, 32'hFFFF_FF00);
        run_random(PHASE_ITEMS);
        settle();

        // Random, no idling on either side
        src_idle_pct = 0;
        snk_idle_pct = 0;
        cfg_write(CFG_FG_COLOR, $urandom);
        cfg_write(CFG_TRANSPARENT, 32'($urandom_range(0, 1)));
        cfg_write(CFG_LINE_WIDTH, 32'd4096);
        cfg_write(CFG_FB_BASE, $urandom);
        run_random(PHASE_ITEMS);
        settle();

        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/gbr_pkg.sv
rtl/gbr_ram.sv
rtl/glyph_bitmap_renderer_top.sv
verif/glyph_bitmap_renderer_checker.sv
verif/glyph_bitmap_renderer_top_tb.sv
